// ===== design/er_pkg.sv =====
`timescale 1ns / 1ps
package er_pkg;
  localparam int ANGLE_WIDTH   = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int NSTAGE        = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
  localparam int CW            = 34;
  localparam logic signed [CW-1:0] Q30_PI      = 34'sd3373259426;
  localparam logic signed [CW-1:0] Q30_HALF_PI = 34'sd1686629713;
  localparam logic signed [CW-1:0] INV_GAIN    = 34'sd652032874;
  localparam int MULT_LAT = 4;

  typedef logic signed [CW-1:0] cw_t;

  // one angle's CORDIC vector
  typedef struct packed {
    cw_t  x;
    cw_t  y;
    cw_t  z;
    logic flip;
  } rot_t;

  typedef struct packed {
    rot_t b;
    rot_t a;
    rot_t h;
  } tri_t;

  function automatic cw_t atan_q30(input int i);
    case (i)
      0: atan_q30 = 34'sd843314857;
      1: atan_q30 = 34'sd497837829;
      2: atan_q30 = 34'sd263043837;
      3: atan_q30 = 34'sd133525159;
      4: atan_q30 = 34'sd67021687;
      5: atan_q30 = 34'sd33543516;
      6: atan_q30 = 34'sd16775851;
      7: atan_q30 = 34'sd8388437;
      8: atan_q30 = 34'sd4194283;
      9: atan_q30 = 34'sd2097149;
      31: atan_q30 = '0;
      default: atan_q30 = cw_t'(64'sd1 <<< (30 - i));
    endcase
  endfunction

  // Q60 -> Q14 with rounding and saturation
  function automatic logic signed [15:0] sat14(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v + (64'sd1 <<< 45)) >>> 46;
    if (r > 64'sd16384) sat14 = 16'sd16384;
    else if (r < -64'sd16384) sat14 = -16'sd16384;
    else sat14 = r[15:0];
  endfunction
endpackage

// ===== design/euler_to_rotation_matrix_unit.sv =====
`timescale 1ns / 1ps
// Euler angles (Q3.13 rad) to 3x3 rotation matrix (Q2.14, saturated to +-1).
// Fully pipelined: one transaction per cycle while the output is not stalled;
// the pipeline is the row of CORDIC cells, the product stages and the output
// register. The whole pipeline stalls while a result waits with out_tready low,
// so no new input enters then; in_tready follows out_tready whenever
// out_tvalid is high.
module euler_to_rotation_matrix_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // bank_angle, attitude_angle, heading_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata   // r00,r01,r02,r10,r11,r12,r20,r21,r22
);
  localparam int N = er_pkg::NSTAGE;
  localparam int AW = er_pkg::ANGLE_WIDTH;

  logic en;
  logic         v [0:N];
  er_pkg::tri_t d [0:N];

  // pipeline advances unless output is held full
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  function automatic er_pkg::rot_t prep(input logic [AW-1:0] raw);
    er_pkg::rot_t r;
    logic signed [63:0] q;
    q = 64'(signed'(raw)) <<< (33 - AW);
    r.x = er_pkg::INV_GAIN;
    r.y = '0;
    r.flip = 1'b0;
    r.z = q[er_pkg::CW-1:0];
    if (r.z > er_pkg::Q30_HALF_PI) begin
      r.z = r.z - er_pkg::Q30_PI; r.flip = 1'b1;
    end else if (r.z < -er_pkg::Q30_HALF_PI) begin
      r.z = r.z + er_pkg::Q30_PI; r.flip = 1'b1;
    end
    return r;
  endfunction

  assign v[0] = in_tvalid;
  always_comb begin
    d[0].b = prep(in_tdata[AW-1:0]);
    d[0].a = prep(in_tdata[2*AW-1:AW]);
    d[0].h = prep(in_tdata[3*AW-1:2*AW]);
  end

  // chain of CORDIC cells
  for (genvar i = 0; i < N; i++) begin : g_cell
    er_cell u_cell (
      .clk(clk), .rst_n(rst_n), .en(en), .stage(5'(i)),
      .vin(v[i]), .din(d[i]), .vout(v[i+1]), .dout(d[i+1])
    );
  end

  // sin/cos to Q20 (22-bit signed)
  function automatic logic signed [21:0] q20(input er_pkg::cw_t t, input logic f);
    er_pkg::cw_t u;
    u = f ? -t : t;
    u = (u + 34'sd512) >>> 10;
    return u[21:0];
  endfunction

  logic signed [21:0] sb_r, cb_r, sa_r, ca_r, sh_r, ch_r;
  logic v1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= v[N];
    if (en) begin
      sb_r <= q20(d[N].b.y, d[N].b.flip); cb_r <= q20(d[N].b.x, d[N].b.flip);
      sa_r <= q20(d[N].a.y, d[N].a.flip); ca_r <= q20(d[N].a.x, d[N].a.flip);
      sh_r <= q20(d[N].h.y, d[N].h.flip); ch_r <= q20(d[N].h.x, d[N].h.flip);
    end
  end

  // stage 2: pairwise products, Q40
  logic signed [43:0] chca_r, shsb_r, chsa_r, chcb_r, cacb_r,
                      casb_r, shca_r, shcb_r, shsa_r, chsb_r;
  logic signed [21:0] sa2_r, cb2_r, sb2_r;
  logic v2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
    if (en) begin
      chca_r <= 44'(ch_r) * 44'(ca_r); shsb_r <= 44'(sh_r) * 44'(sb_r);
      chsa_r <= 44'(ch_r) * 44'(sa_r); chcb_r <= 44'(ch_r) * 44'(cb_r);
      cacb_r <= 44'(ca_r) * 44'(cb_r); casb_r <= 44'(ca_r) * 44'(sb_r);
      shca_r <= 44'(sh_r) * 44'(ca_r); shcb_r <= 44'(sh_r) * 44'(cb_r);
      shsa_r <= 44'(sh_r) * 44'(sa_r); chsb_r <= 44'(ch_r) * 44'(sb_r);
      sa2_r <= sa_r; cb2_r <= cb_r; sb2_r <= sb_r;
    end
  end

  // stage 3: triple products, Q60
  logic signed [63:0] t01_r, t02_r, t21_r, t22_r;
  logic signed [43:0] p00_r, p01_r, p02_r, p11_r, p12_r, p20_r, p21_r, p22_r;
  logic signed [21:0] sa3_r;
  logic v3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
    if (en) begin
      t01_r <= 64'(chsa_r) * 64'(cb2_r);
      t02_r <= 64'(chsa_r) * 64'(sb2_r);
      t21_r <= 64'(shsa_r) * 64'(cb2_r);
      t22_r <= 64'(shsa_r) * 64'(sb2_r);
      p00_r <= chca_r; p01_r <= shsb_r; p02_r <= shcb_r; p11_r <= cacb_r;
      p12_r <= casb_r; p20_r <= shca_r; p21_r <= chsb_r; p22_r <= chcb_r;
      sa3_r <= sa2_r;
    end
  end

  // stage 4: sums in Q60
  logic signed [63:0] s_r [0:8];
  logic v4_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
    if (en) begin
      s_r[0] <= 64'(p00_r) <<< 20;
      s_r[1] <= (64'(p01_r) <<< 20) - t01_r;
      s_r[2] <= t02_r + (64'(p02_r) <<< 20);
      s_r[3] <= 64'(sa3_r) <<< 40;
      s_r[4] <= 64'(p11_r) <<< 20;
      s_r[5] <= -(64'(p12_r) <<< 20);
      s_r[6] <= -(64'(p20_r) <<< 20);
      s_r[7] <= t21_r + (64'(p21_r) <<< 20);
      s_r[8] <= (64'(p22_r) <<< 20) - t22_r;
    end
  end

  // output register
  logic ov_r;
  logic [143:0] od_r;
  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= v4_r;
    if (en) for (int k = 0; k < 9; k++) od_r[16*k +: 16] <= er_pkg::sat14(s_r[k]);
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
endmodule

// ===== design/er_cell.sv =====
`timescale 1ns / 1ps
// One CORDIC micro-rotation for all three angles, registered.
module er_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic [4:0]    stage,  // micro-rotation index, tied per cell
  input  logic          vin,
  input  er_pkg::tri_t  din,
  output logic          vout,
  output er_pkg::tri_t  dout
);
  er_pkg::tri_t d_nxt, d_r;
  logic v_r;

  function automatic er_pkg::rot_t step(input er_pkg::rot_t r, input int s);
    er_pkg::rot_t o;
    er_pkg::cw_t xs, ys;
    xs = r.x >>> s;
    ys = r.y >>> s;
    o = r;
    if (!r.z[er_pkg::CW-1]) begin
      o.x = r.x - ys; o.y = r.y + xs; o.z = r.z - er_pkg::atan_q30(s);
    end else begin
      o.x = r.x + ys; o.y = r.y - xs; o.z = r.z + er_pkg::atan_q30(s);
    end
    return o;
  endfunction

  always_comb begin
    d_nxt.b = step(din.b, int'(stage));
    d_nxt.a = step(din.a, int'(stage));
    d_nxt.h = step(din.h, int'(stage));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else if (en) v_r <= vin;
    if (en) d_r <= d_nxt;
  end

  assign vout = v_r;
  assign dout = d_r;
endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;

  localparam int LATENCY = er_pkg::NSTAGE + er_pkg::MULT_LAT + 1;
  localparam longint CYCLE_LIMIT = 400000;
  localparam longint Q30_PI_L = 64'sd3373259426;
  localparam longint Q30_HALF_PI_L = 64'sd1686629713;
  localparam longint INV_GAIN_L = 64'sd652032874;
  localparam int A_MAX = 25736;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [47:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [143:0] out_tdata;

  logic [143:0] expected_matrices[$];
  int errors;
  longint cycles;
  int gap_pct;  // idle percentage of both sides

  euler_to_rotation_matrix_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // floor shift
  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  // CORDIC sine/cosine in Q20 of a raw angle field
  function automatic void sincos(input logic signed [15:0] raw,
                                 output longint s, output longint c);
    longint x, y, z, xs, ys, t;
    bit flip;
    x = INV_GAIN_L; y = 0;
    z = longint'(raw) * (64'sd1 <<< (33 - er_pkg::ANGLE_WIDTH));
    flip = 0;
    if (z > Q30_HALF_PI_L) begin
      z -= Q30_PI_L; flip = 1;
    end else if (z < -Q30_HALF_PI_L) begin
      z += Q30_PI_L; flip = 1;
    end
    for (int i = 0; i < er_pkg::NSTAGE; i++) begin
      xs = shr_floor(x, i);
      ys = shr_floor(y, i);
      t = longint'(er_pkg::atan_q30(i));
      if (z >= 0) begin
        x -= ys; y += xs; z -= t;
      end else begin
        x += ys; y -= xs; z += t;
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = shr_floor(x + 512, 10);
    s = shr_floor(y + 512, 10);
  endfunction

  function automatic logic [15:0] to_q14(longint v);
    longint r;
    r = shr_floor(v + (64'sd1 <<< 45), 46);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r[15:0];
  endfunction

  function automatic logic [143:0] rotation_matrix(logic [47:0] angles);
    longint sb, cb, sa, ca, sh, ch;
    longint k20, k40;
    logic [15:0] e[9];
    k20 = 64'sd1 <<< 20; k40 = 64'sd1 <<< 40;
    sincos(angles[15:0], sb, cb);
    sincos(angles[31:16], sa, ca);
    sincos(angles[47:32], sh, ch);
    e[0] = to_q14(ch * ca * k20);
    e[1] = to_q14(sh * sb * k20 - ch * sa * cb);
    e[2] = to_q14(ch * sa * sb + sh * cb * k20);
    e[3] = to_q14(sa * k40);
    e[4] = to_q14(ca * cb * k20);
    e[5] = to_q14(-(ca * sb) * k20);
    e[6] = to_q14(-(sh * ca) * k20);
    e[7] = to_q14(sh * sa * cb + ch * sb * k20);
    e[8] = to_q14(ch * cb * k20 - sh * sa * sb);
    return {e[8], e[7], e[6], e[5], e[4], e[3], e[2], e[1], e[0]};
  endfunction

  task automatic report_mismatch(string what);
    $display("MISMATCH at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  // send one angle triple: bank, attitude, heading
  task automatic send_angles(logic signed [15:0] b, logic signed [15:0] a,
                             logic signed [15:0] h);
    while ($urandom_range(99) < gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {h, a, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_matrices = {expected_matrices, rotation_matrix({h, a, b})};
  endtask

  function automatic logic signed [15:0] rand_angle();
    return 16'($signed($urandom_range(2 * A_MAX)) - A_MAX);
  endfunction

  // result checker and output stall
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (expected_matrices.size() == 0) begin
          report_mismatch("result with none expected");
        end else begin
          logic [143:0] want;
          want = expected_matrices.pop_front();
          for (int k = 0; k < 9; k++)
            if (out_tdata[16*k +: 16] !== want[16*k +: 16])
              report_mismatch($sformatf("entry %0d got %0d want %0d", k,
                $signed(out_tdata[16*k +: 16]), $signed(want[16*k +: 16])));
        end
      end
      out_tready <= ($urandom_range(99) >= gap_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("euler_to_rotation_matrix_unit test failed");
      $finish;
    end
  end

  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_matrices.size() != 0) @(posedge clk);
  endtask

  // zeros, extremes, quadrant edges around +-pi/2
  task automatic test_directed();
    logic signed [15:0] v[10];
    v = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
          16'sd12869, -16'sd12869, 16'sd1, -16'sd1, 16'sd6434};
    for (int i = 0; i < 10; i++) send_angles(v[i], 16'sd0, 16'sd0);
    for (int i = 0; i < 5; i++) send_angles(16'sd0, v[i], 16'sd0);
    for (int i = 0; i < 5; i++) send_angles(16'sd0, 16'sd0, v[i]);
    send_angles(16'sd25736, 16'sd25736, 16'sd25736);
    send_angles(-16'sd25736, 16'sd12868, -16'sd12868);
    // codes outside +-pi, mixed with in-range codes
    send_angles(16'h7fff, 16'h8000, 16'hffff);
    send_angles(16'h8000, 16'h7fff, 16'h5555);
    drain();
  endtask

  task automatic test_random(int n, int pct);
    gap_pct = pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_angles(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_angles(rand_angle(), rand_angle(), rand_angle());
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    gap_pct = 25;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(400, 25);
    drain();
    test_random(200, 0);
    test_random(300, 25);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("euler_to_rotation_matrix_unit test passed");
    end else begin
      $display("euler_to_rotation_matrix_unit test failed");
    end
    $finish;
  end
endmodule
